@@ design/psc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // tracked sequence space and bitmap geometry
    localparam int MAX_SEQUENCES = 65536;
    localparam int MAP_BITS      = 64;
    localparam int BIT_W         = $clog2(MAP_BITS);
    localparam int MAP_WORDS     = (MAX_SEQUENCES + MAP_BITS - 1) / MAP_BITS;
    localparam int MAP_AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // field widths
    localparam int CNT_W   = 17;   // expected count, unique count, next sequence
    localparam int TOT_W   = 32;
    localparam int BYTE_W  = 48;
    localparam int LEN_W   = 14;
    localparam int TS_W    = 64;
    localparam int THB_W   = 8;
    localparam int IDX_W   = 2;

    // effective cap on the expected count as seen through a 17-bit register
    localparam logic [CNT_W-1:0] MAX_SEQ_CAP =
        (MAX_SEQUENCES > (2 ** CNT_W) - 1) ? CNT_W'((2 ** CNT_W) - 1)
                                           : CNT_W'(MAX_SEQUENCES);

    // header sizes
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam int ETH_BYTES    = 14;
    localparam int IP_MIN_WORDS = 5;
    localparam int UDP_BYTES    = 8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_EXPECTED_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_TEST_HDR_BYTES = 2'd1;
    localparam logic [IDX_W-1:0] REG_SKIP_LATENCY   = 2'd2;

    typedef enum logic [2:0] {
        V_IN_ORDER = 3'd0,
        V_AHEAD    = 3'd1,
        V_LATE     = 3'd2,
        V_DUP      = 3'd3,
        V_BEYOND   = 3'd4,
        V_SHORT    = 3'd5
    } t_verdict;

endpackage

`default_nettype wire

@@ design/psc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// simple dual port RAM, registered read, read returns old data on collision
module psc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/packet_sequence_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: stage 1 (bitmap read), then the output register (bitmap update, result valid).
// Throughput: one frame per cycle unless the result channel stalls; the seen bitmap word
// read-modify-write is pipelined over one RAM read port and one write port with write
// forwarding. Reset: synchronous, active low; afterwards a clearing pass zeroes
// the bitmap's MAP_WORDS (1024) words one per cycle, with no input accepted meanwhile.
module packet_sequence_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [psc_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [psc_pkg::CNT_W-1:0]   i_cfg_data,
    // input frame channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [psc_pkg::LEN_W-1:0]   i_frame_len,
    input  wire logic [15:0]                 i_ether_type,
    input  wire logic [3:0]                  i_ip_header_words,
    input  wire logic [63:0]                 i_sequence_req,
    input  wire logic [psc_pkg::TS_W-1:0]    i_send_time_ns,
    input  wire logic [psc_pkg::TS_W-1:0]    i_arrival_time_ns,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [2:0]                       o_verdict,
    output logic                             o_latency_valid,
    output logic [psc_pkg::TS_W-1:0]         o_latency_ns,
    output logic [psc_pkg::TOT_W-1:0]        o_received_total,
    output logic [psc_pkg::CNT_W-1:0]        o_unique_total,
    output logic [psc_pkg::TOT_W-1:0]        o_duplicate_total,
    output logic [psc_pkg::TOT_W-1:0]        o_reorder_total,
    output logic [psc_pkg::TOT_W-1:0]        o_short_total,
    output logic [psc_pkg::CNT_W-1:0]        o_next_expected,
    output logic [psc_pkg::BYTE_W-1:0]       o_byte_total
);
    import psc_pkg::*;

    localparam int HLEN_W = LEN_W + 1;

    // configuration
    logic [CNT_W-1:0] r_expected_count;
    logic [THB_W-1:0] r_test_hdr_bytes;
    logic             r_skip_latency;

    // clearing pass
    logic              r_clr_busy;
    logic [MAP_AW-1:0] r_clr_addr;

    // stage 1 (bitmap word in flight)
    logic              r_s1_valid;
    logic              r_s1_short;
    logic              r_s1_inrange;
    logic [CNT_W-1:0]  r_s1_seq;
    logic [MAP_AW-1:0] r_s1_addr;
    logic [BIT_W-1:0]  r_s1_bit;
    logic [LEN_W-1:0]  r_s1_flen;
    logic              r_s1_lat_ok;
    logic [TS_W-1:0]   r_s1_lat;

    // last bitmap write, forwarded to the next read
    logic                r_fwd_valid;
    logic [MAP_AW-1:0]   r_fwd_addr;
    logic [MAP_BITS-1:0] r_fwd_data;

    // counters
    logic [CNT_W-1:0]  r_next_seq,   n_next_seq;
    logic [TOT_W-1:0]  r_received,   n_received;
    logic [CNT_W-1:0]  r_unique,     n_unique;
    logic [TOT_W-1:0]  r_duplicate,  n_duplicate;
    logic [TOT_W-1:0]  r_reorder,    n_reorder;
    logic [TOT_W-1:0]  r_short,      n_short;
    logic [BYTE_W-1:0] r_bytes,      n_bytes;
    logic [CNT_W-1:0]  r_samples,    n_samples;

    // output register
    logic              r_out_valid;

    logic              in_accept;
    logic              s1_advance;
    logic              s1_commit;
    logic [CNT_W-1:0]  limit;
    logic [HLEN_W-1:0] min_len;
    logic              in_short;
    logic              in_range;
    logic [MAP_BITS-1:0] ram_rdata;
    logic [MAP_BITS-1:0] cur_word;
    logic              seen;
    logic              map_set;
    logic              lat_emit;
    t_verdict          verdict;
    logic [BYTE_W:0]   byte_sum;
    logic              ram_we;
    logic [MAP_AW-1:0] ram_waddr;
    logic [MAP_BITS-1:0] ram_wdata;

    // handshake
    assign s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_advance);
    assign in_accept  = i_in_valid && o_in_ready;
    assign s1_commit  = r_s1_valid && s1_advance;

    // effective tracked count and frame parse check
    assign limit   = (r_expected_count > MAX_SEQ_CAP) ? MAX_SEQ_CAP : r_expected_count;
    assign min_len = HLEN_W'(ETH_BYTES + UDP_BYTES) + HLEN_W'({i_ip_header_words, 2'b00})
                   + HLEN_W'(r_test_hdr_bytes);
    assign in_short = (i_ether_type != ETHERTYPE_IPV4)
                   || (i_ip_header_words < 4'(IP_MIN_WORDS))
                   || (HLEN_W'(i_frame_len) < min_len);
    assign in_range = i_sequence_req < 64'(limit);

    // bitmap storage
    psc_ram #(
        .WIDTH (MAP_BITS),
        .DEPTH (MAP_WORDS)
    ) u_seen_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_sequence_req[BIT_W +: MAP_AW]),
        .o_rdata (ram_rdata)
    );

    // classify the frame in stage 1
    always_comb begin
        cur_word    = (r_fwd_valid && r_fwd_addr == r_s1_addr) ? r_fwd_data : ram_rdata;
        seen        = cur_word[r_s1_bit];
        map_set     = 1'b0;
        lat_emit    = 1'b0;
        verdict     = V_SHORT;
        n_next_seq  = r_next_seq;
        n_unique    = r_unique;
        n_duplicate = r_duplicate;
        n_reorder   = r_reorder;
        n_short     = r_short;
        n_samples   = r_samples;
        n_received  = (r_received == '1) ? r_received : r_received + 1'b1;
        byte_sum    = {1'b0, r_bytes} + (BYTE_W + 1)'(r_s1_flen);
        n_bytes     = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];

        if (r_s1_short) begin
            n_short = (r_short == '1) ? r_short : r_short + 1'b1;
            verdict = V_SHORT;
        end else begin
            if (r_s1_inrange) begin
                if (seen) begin
                    n_duplicate = (r_duplicate == '1) ? r_duplicate : r_duplicate + 1'b1;
                    verdict     = V_DUP;
                end else begin
                    map_set  = 1'b1;
                    n_unique = (r_unique == '1) ? r_unique : r_unique + 1'b1;
                    if (r_s1_seq == r_next_seq) begin
                        n_next_seq = r_s1_seq + 1'b1;
                        verdict    = V_IN_ORDER;
                    end else if (r_s1_seq > r_next_seq) begin
                        n_reorder  = (r_reorder == '1) ? r_reorder : r_reorder + 1'b1;
                        n_next_seq = r_s1_seq + 1'b1;
                        verdict    = V_AHEAD;
                    end else begin
                        n_reorder = (r_reorder == '1) ? r_reorder : r_reorder + 1'b1;
                        verdict   = V_LATE;
                    end
                end
            end else begin
                n_reorder = (r_reorder == '1) ? r_reorder : r_reorder + 1'b1;
                verdict   = V_BEYOND;
            end
            if (!r_skip_latency && r_samples < limit && r_s1_lat_ok) begin
                lat_emit  = 1'b1;
                n_samples = (r_samples == '1) ? r_samples : r_samples + 1'b1;
            end
        end
    end

    // bitmap write port: clearing pass or bit set
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_commit && map_set;
            ram_waddr = r_s1_addr;
            ram_wdata = cur_word | (MAP_BITS'(1) << r_s1_bit);
        end
    end

    // control, configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_count <= CNT_W'(65536);
            r_test_hdr_bytes <= THB_W'(16);
            r_skip_latency   <= 1'b0;
            r_clr_busy       <= 1'b1;
            r_clr_addr       <= '0;
            r_s1_valid       <= 1'b0;
            r_fwd_valid      <= 1'b0;
            r_out_valid      <= 1'b0;
            r_next_seq       <= '0;
            r_received       <= '0;
            r_unique         <= '0;
            r_duplicate      <= '0;
            r_reorder        <= '0;
            r_short          <= '0;
            r_bytes          <= '0;
            r_samples        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_EXPECTED_COUNT: r_expected_count <= i_cfg_data;
                    REG_TEST_HDR_BYTES: r_test_hdr_bytes <= i_cfg_data[THB_W-1:0];
                    REG_SKIP_LATENCY:   r_skip_latency   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == MAP_AW'(MAP_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end

            if (ram_we && !r_clr_busy) begin
                r_fwd_valid <= 1'b1;
            end

            if (s1_commit) begin
                r_out_valid <= 1'b1;
                r_next_seq  <= n_next_seq;
                r_received  <= n_received;
                r_unique    <= n_unique;
                r_duplicate <= n_duplicate;
                r_reorder   <= n_reorder;
                r_short     <= n_short;
                r_bytes     <= n_bytes;
                r_samples   <= n_samples;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_short   <= in_short;
            r_s1_inrange <= in_range;
            r_s1_seq     <= i_sequence_req[CNT_W-1:0];
            r_s1_addr    <= i_sequence_req[BIT_W +: MAP_AW];
            r_s1_bit     <= i_sequence_req[BIT_W-1:0];
            r_s1_flen    <= i_frame_len;
            r_s1_lat_ok  <= i_arrival_time_ns >= i_send_time_ns;
            r_s1_lat     <= i_arrival_time_ns - i_send_time_ns;
        end
        if (ram_we && !r_clr_busy) begin
            r_fwd_addr <= ram_waddr;
            r_fwd_data <= ram_wdata;
        end
        if (s1_commit) begin
            o_verdict         <= verdict;
            o_latency_valid   <= lat_emit;
            o_latency_ns      <= lat_emit ? r_s1_lat : '0;
            o_received_total  <= n_received;
            o_unique_total    <= n_unique;
            o_duplicate_total <= n_duplicate;
            o_reorder_total   <= n_reorder;
            o_short_total     <= n_short;
            o_next_expected   <= n_next_seq;
            o_byte_total      <= n_bytes;
        end
    end

    assign o_out_valid = r_out_valid;

    // no frame is in flight while the bitmap is being cleared
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!o_in_ready && !r_s1_valid))
        else $error("frame in flight during bitmap clear");

    // a new distinct sequence always sets its bit in the bitmap
    a_unique_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_commit && n_unique != r_unique) |-> ram_we)
        else $error("unique count advanced without bitmap write");

    // the unique count can never pass the number of frames received
    a_unique_le_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TOT_W'(r_unique) <= r_received)
        else $error("unique count above received count");

    // latency samples only for parsed frames, zero otherwise
    a_lat_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_latency_valid) |-> (o_verdict != V_SHORT))
        else $error("latency sample on short frame");

    a_lat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_latency_valid) |-> (o_latency_ns == '0))
        else $error("latency not zero without sample");

endmodule

`default_nettype wire
